FILE: rtl/core/alsm_pkg.sv
// ----------------------------------------------------------------------------
// alsm_pkg
// Shared types and constants for the anchored line substring matcher.
// ----------------------------------------------------------------------------
package alsm_pkg;

   localparam int PATTERN_MAX_DEFAULT   = 16;
   localparam int POSITION_BITS_DEFAULT = 16;

   // Fixed by the register map: sixteen pattern bytes, 5-bit length field
   localparam int PAT_BYTES  = 16;
   localparam int LEN_BITS   = 5;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int LINE_BITS  = 32;

   // Item codes on the input channel
   localparam logic FUNC_CHAR = 1'b0;
   localparam logic FUNC_EOL  = 1'b1;

   typedef enum logic [2:0] {
      MODE_EXACT       = 3'd0,
      MODE_ENDS_WITH   = 3'd1,
      MODE_STARTS_WITH = 3'd2,
      MODE_CONTAINS    = 3'd3,
      MODE_AT_ONE      = 3'd4,
      MODE_ENDS_BEFORE = 3'd5,
      MODE_ONE_OR_PRE  = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      REG_PATTERN_LOW  = 2'd0,
      REG_PATTERN_HIGH = 2'd1,
      REG_PATTERN_LEN  = 2'd2,
      REG_MATCH_MODE   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [PAT_BYTES-1:0][7:0] pattern;
      logic [LEN_BITS-1:0]       length;
      mode_type                  mode;
   } cfg_type;

endpackage

FILE: rtl/core/alsm_csr.sv
// ----------------------------------------------------------------------------
// alsm_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module alsm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [alsm_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [alsm_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [alsm_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output alsm_pkg::cfg_type                cfg
);

   logic [63:0]                   pat_low_ff,  pat_low_in;
   logic [63:0]                   pat_high_ff, pat_high_in;
   logic [alsm_pkg::LEN_BITS-1:0] len_ff,      len_in;
   alsm_pkg::mode_type            mode_ff,     mode_in;
   alsm_pkg::reg_index_type       sel;
   logic                          wr_en;

   assign pready = 1'b1;
   assign sel    = alsm_pkg::reg_index_type'(paddr[4:3]);
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      len_in      = len_ff;
      mode_in     = mode_ff;
      if (wr_en) begin
         case (sel)
            alsm_pkg::REG_PATTERN_LOW:  pat_low_in  = pwdata;
            alsm_pkg::REG_PATTERN_HIGH: pat_high_in = pwdata;
            alsm_pkg::REG_PATTERN_LEN:  len_in      = pwdata[alsm_pkg::LEN_BITS-1:0];
            alsm_pkg::REG_MATCH_MODE:   mode_in     = alsm_pkg::mode_type'(pwdata[2:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         len_ff      <= '0;
         mode_ff     <= alsm_pkg::MODE_CONTAINS;
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         len_ff      <= len_in;
         mode_ff     <= mode_in;
      end
   end

   always_comb begin
      case (sel)
         alsm_pkg::REG_PATTERN_LOW:  prdata = pat_low_ff;
         alsm_pkg::REG_PATTERN_HIGH: prdata = pat_high_ff;
         alsm_pkg::REG_PATTERN_LEN:
            prdata = {{(alsm_pkg::CSR_DATA_W-alsm_pkg::LEN_BITS){1'b0}}, len_ff};
         alsm_pkg::REG_MATCH_MODE:
            prdata = {{(alsm_pkg::CSR_DATA_W-3){1'b0}}, mode_ff};
         default: prdata = '0;
      endcase
   end

   assign cfg.pattern = {pat_high_ff, pat_low_ff};
   assign cfg.length  = len_ff;
   assign cfg.mode    = mode_ff;

endmodule

FILE: rtl/core/alsm_window.sv
// ----------------------------------------------------------------------------
// alsm_window
// Shift window of the newest text bytes with parallel pattern comparators.
// ----------------------------------------------------------------------------
module alsm_window #(
   parameter int PATTERN_MAX = alsm_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  shift_en,
   input  logic [7:0]                            char_in,
   input  logic [alsm_pkg::LEN_BITS-1:0]         len,
   input  logic [alsm_pkg::PAT_BYTES-1:0][7:0]   pattern,
   output logic                                  bytes_match
);

   logic [PATTERN_MAX-1:0][7:0] win_ff, win_in;
   logic [PATTERN_MAX-1:0]      byte_ok;

   // newest byte in slot 0, the rest move one slot older
   always_comb begin
      win_in[0] = char_in;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         win_in[k] = win_ff[k-1];
      end
   end

   // slot k holds the byte that pairs with pattern byte len-1-k
   always_comb begin
      logic [alsm_pkg::LEN_BITS-1:0] idx;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         idx = len - alsm_pkg::LEN_BITS'(k) - alsm_pkg::LEN_BITS'(1);
         if (alsm_pkg::LEN_BITS'(k) < len) begin
            byte_ok[k] = (win_in[k] == pattern[idx[3:0]]);
         end else begin
            byte_ok[k] = 1'b1;
         end
      end
   end

   assign bytes_match = &byte_ok;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         win_ff <= win_in;
      end
   end

endmodule

FILE: rtl/core/anchored_line_substring_matcher_unit.sv
// ----------------------------------------------------------------------------
// anchored_line_substring_matcher_unit
// Line-by-line literal pattern matcher with anchored match modes.
// ----------------------------------------------------------------------------
// Feed text one byte per item (req_func low) and close each line with an
// end-of-line item (req_func high); every end-of-line item yields one result
// carrying the saturating one-based line number and the match flag, byte items
// yield nothing. The block takes one item per clock cycle, except when an
// end-of-line item must wait for the result register: each item is held in
// an input register, where the newest bytes are compared against all pattern
// bytes at once by the parallel comparators of the shift window. A result is
// registered on the rsp_ channel when its end-of-line item leaves the input
// register; only an end-of-line item waiting behind a result that has not
// been taken holds the input. Program the pattern, its length and the match
// mode through the register port while the block is idle; a length above the
// window depth counts as the full depth, and mode 7 never matches.
// ----------------------------------------------------------------------------
module anchored_line_substring_matcher_unit #(
   parameter int PATTERN_MAX   = alsm_pkg::PATTERN_MAX_DEFAULT,
   parameter int POSITION_BITS = alsm_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input items
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_func,
   input  logic [7:0]                           req_character,
   // results
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [alsm_pkg::LINE_BITS-1:0]       rsp_line_number,
   output logic                                 rsp_line_matched,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [alsm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [alsm_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [alsm_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   localparam logic [POSITION_BITS-1:0] PosMax = '1;

   alsm_pkg::cfg_type cfg;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_func_ff;
   logic [7:0] in_char_ff;

   // line state
   logic [POSITION_BITS-1:0]       pos_ff,          pos_in;
   logic                           at_start_ff,     at_start_in;
   logic                           at_one_ff,       at_one_in;
   logic                           anywhere_ff,     anywhere_in;
   logic                           ends_now_ff,     ends_now_in;
   logic                           ended_before_ff, ended_before_in;
   logic [alsm_pkg::LINE_BITS-1:0] line_cnt_ff,     line_cnt_in;

   // result register
   logic                           out_valid_ff, out_valid_in;
   logic [alsm_pkg::LINE_BITS-1:0] out_line_ff;
   logic                           out_match_ff;

   logic                           out_free;
   logic                           drain;
   logic                           take_byte;
   logic                           take_eol;
   logic [alsm_pkg::LEN_BITS-1:0]  len;
   logic [POSITION_BITS-1:0]       len_ext;
   logic [POSITION_BITS-1:0]       pos_next;
   logic                           bytes_match;
   logic                           hit;
   logic                           decision;

   alsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // clamp the length to the window depth
   assign len = (cfg.length > alsm_pkg::LEN_BITS'(PATTERN_MAX)) ?
                alsm_pkg::LEN_BITS'(PATTERN_MAX) : cfg.length;
   assign len_ext = POSITION_BITS'(len);

   // an end-of-line item may only leave the input register if the result
   // register is free or being emptied this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   assign drain     = in_valid_ff && ((in_func_ff == alsm_pkg::FUNC_CHAR) || out_free);
   assign take_byte = drain && (in_func_ff == alsm_pkg::FUNC_CHAR);
   assign take_eol  = drain && (in_func_ff == alsm_pkg::FUNC_EOL);
   assign req_ready = !in_valid_ff || drain;

   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !drain);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_func_ff <= req_func;
         in_char_ff <= req_character;
      end
   end

   alsm_window #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_window (
      .clock       (clock),
      .shift_en    (take_byte),
      .char_in     (in_char_ff),
      .len         (len),
      .pattern     (cfg.pattern),
      .bytes_match (bytes_match)
   );

   // saturating position of the byte being taken
   assign pos_next = (pos_ff == PosMax) ? pos_ff : pos_ff + POSITION_BITS'(1);
   assign hit      = bytes_match && (pos_next >= len_ext);

   // end-of-line decision on the flags gathered so far
   always_comb begin
      if (len == '0) begin
         case (cfg.mode)
            alsm_pkg::MODE_EXACT:       decision = (pos_ff == '0);
            alsm_pkg::MODE_ENDS_WITH,
            alsm_pkg::MODE_STARTS_WITH,
            alsm_pkg::MODE_CONTAINS:    decision = 1'b1;
            alsm_pkg::MODE_AT_ONE,
            alsm_pkg::MODE_ENDS_BEFORE,
            alsm_pkg::MODE_ONE_OR_PRE:  decision = (pos_ff != '0);
            default:                    decision = 1'b0;
         endcase
      end else begin
         case (cfg.mode)
            alsm_pkg::MODE_EXACT:       decision = at_start_ff && (pos_ff == len_ext);
            alsm_pkg::MODE_ENDS_WITH:   decision = ends_now_ff;
            alsm_pkg::MODE_STARTS_WITH: decision = at_start_ff;
            alsm_pkg::MODE_CONTAINS:    decision = anywhere_ff;
            alsm_pkg::MODE_AT_ONE:      decision = at_one_ff;
            alsm_pkg::MODE_ENDS_BEFORE: decision = ended_before_ff;
            alsm_pkg::MODE_ONE_OR_PRE:  decision = at_one_ff || ended_before_ff;
            default:                    decision = 1'b0;
         endcase
      end
   end

   // advance the line state on a byte, clear it at the line end
   always_comb begin
      pos_in          = pos_ff;
      at_start_in     = at_start_ff;
      at_one_in       = at_one_ff;
      anywhere_in     = anywhere_ff;
      ends_now_in     = ends_now_ff;
      ended_before_in = ended_before_ff;
      line_cnt_in     = line_cnt_ff;
      if (take_byte) begin
         pos_in          = pos_next;
         ended_before_in = ends_now_ff;
         ends_now_in     = hit;
         if (hit) begin
            anywhere_in = 1'b1;
            if (pos_next == len_ext) begin
               at_start_in = 1'b1;
            end
            if (pos_next == len_ext + POSITION_BITS'(1)) begin
               at_one_in = 1'b1;
            end
         end
      end else if (take_eol) begin
         pos_in          = '0;
         at_start_in     = 1'b0;
         at_one_in       = 1'b0;
         anywhere_in     = 1'b0;
         ends_now_in     = 1'b0;
         ended_before_in = 1'b0;
         if (line_cnt_ff != '1) begin
            line_cnt_in = line_cnt_ff + alsm_pkg::LINE_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         at_start_ff     <= 1'b0;
         at_one_ff       <= 1'b0;
         anywhere_ff     <= 1'b0;
         ends_now_ff     <= 1'b0;
         ended_before_ff <= 1'b0;
         line_cnt_ff     <= '0;
      end else begin
         pos_ff          <= pos_in;
         at_start_ff     <= at_start_in;
         at_one_ff       <= at_one_in;
         anywhere_ff     <= anywhere_in;
         ends_now_ff     <= ends_now_in;
         ended_before_ff <= ended_before_in;
         line_cnt_ff     <= line_cnt_in;
      end
   end

   // result register: load on a line end, drop once taken
   always_comb begin
      if (take_eol) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_eol) begin
         out_line_ff  <= line_cnt_in;
         out_match_ff <= decision;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_line_number  = out_line_ff;
   assign rsp_line_matched = out_match_ff;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the anchored line substring matcher.
// ----------------------------------------------------------------------------
// Text bytes and end-of-line items go in over a valid/ready channel. A line
// predictor inside a small scoreboard class turns every accepted item into the
// expected line number and match flag. A monitor compares each result taken
// from the block against the oldest prediction. The register port is used
// only while the block is idle, and every write is read back. The run covers a
// short directed part and random phases under random settings, including a
// long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
   import alsm_pkg::*;

   localparam int         HALF_PERIOD    = 5;
   localparam int         RESET_CYCLES   = 9;
   localparam int         POS_BITS       = POSITION_BITS_DEFAULT;
   localparam logic [2:0] MODE_UNUSED    = 3'd7;
   localparam int         RANDOM_ITEMS   = 700;
   localparam int         QUIET_ITEMS    = 200;   // random items sent with no idling at all
   localparam int         PRESSURE_AFTER = 300;
   localparam int         RX_HOLD_CYCLES = 150;
   localparam int         SETTLE_CYCLES  = 4;     // margin after the last result before the register port is used
   localparam int         DRAIN_CYCLES   = 20;
   localparam int         CYCLE_LIMIT    = 600000;
   localparam int         PRINT_LIMIT    = 100;

   typedef struct packed {
      logic [LINE_BITS-1:0] number;
      logic                 matched;
   } line_verdict_type;

   // -------------------------------------------------------------------------
   // Line predictor and result store
   // -------------------------------------------------------------------------
   class line_verdict_tracker;
      logic [CSR_DATA_W-1:0] pattern_lo;
      logic [CSR_DATA_W-1:0] pattern_hi;
      logic [LEN_BITS-1:0]   pattern_len;
      logic [2:0]            mode;
      logic [7:0]            window [PAT_BYTES];
      logic [POS_BITS-1:0]   position;
      bit                    at_start;
      bit                    at_one;
      bit                    anywhere;
      bit                    ends_now;
      bit                    ended_before;
      logic [LINE_BITS-1:0]  line_count;
      line_verdict_type      verdicts_due [$];
      int                    fail_count;
      int                    lines_closed;
      int                    lines_matched;

      function new();
         pattern_lo    = '0;
         pattern_hi    = '0;
         pattern_len   = '0;
         mode          = MODE_CONTAINS;
         foreach (window[i]) window[i] = 8'h00;
         line_count    = '0;
         fail_count    = 0;
         lines_closed  = 0;
         lines_matched = 0;
         clear_line();
      endfunction

      function void clear_line();
         position     = '0;
         at_start     = 1'b0;
         at_one       = 1'b0;
         anywhere     = 1'b0;
         ends_now     = 1'b0;
         ended_before = 1'b0;
      endfunction

      function int used_length();
         return (pattern_len > PAT_BYTES) ? PAT_BYTES : int'(pattern_len);
      endfunction

      function logic [7:0] pattern_byte(input int i);
         return (i < 8) ? pattern_lo[8*i +: 8] : pattern_hi[8*(i-8) +: 8];
      endfunction

      function void write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_PATTERN_LOW:  pattern_lo  = value;
            REG_PATTERN_HIGH: pattern_hi  = value;
            REG_PATTERN_LEN:  pattern_len = value[LEN_BITS-1:0];
            REG_MATCH_MODE:   mode        = value[2:0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_W-1:0] reg_value(input reg_index_type idx);
         case (idx)
            REG_PATTERN_LOW:  return pattern_lo;
            REG_PATTERN_HIGH: return pattern_hi;
            REG_PATTERN_LEN:  return CSR_DATA_W'(pattern_len);
            default:          return CSR_DATA_W'(mode);
         endcase
      endfunction

      // Shift the byte in and record any occurrence ending at it, using the
      // pattern in force right now.
      function void take_byte(input logic [7:0] c);
         int len;
         int i;
         int first;
         bit hit;
         len = used_length();
         for (i = PAT_BYTES - 1; i > 0; i--) window[i] = window[i-1];
         window[0] = c;
         if (position != '1) position++;
         hit = (int'(position) >= len);
         for (i = 0; i < len; i++)
            if (window[len-1-i] != pattern_byte(i)) hit = 1'b0;
         ended_before = ends_now;
         ends_now     = hit;
         if (hit) begin
            first    = int'(position) - len;
            anywhere = 1'b1;
            if (first == 0) at_start = 1'b1;
            if (first == 1) at_one = 1'b1;
         end
      endfunction

      function bit line_decision();
         int len;
         len = used_length();
         if (len == 0) begin
            case (mode)
               MODE_EXACT:                                     return position == 0;
               MODE_ENDS_WITH, MODE_STARTS_WITH, MODE_CONTAINS: return 1'b1;
               MODE_AT_ONE, MODE_ENDS_BEFORE, MODE_ONE_OR_PRE: return position != 0;
               default:                                        return 1'b0;
            endcase
         end
         case (mode)
            MODE_EXACT:       return at_start && (int'(position) == len);
            MODE_ENDS_WITH:   return ends_now;
            MODE_STARTS_WITH: return at_start;
            MODE_CONTAINS:    return anywhere;
            MODE_AT_ONE:      return at_one;
            MODE_ENDS_BEFORE: return ended_before;
            MODE_ONE_OR_PRE:  return at_one || ended_before;
            default:          return 1'b0;
         endcase
      endfunction

      function void note_input(input logic func, input logic [7:0] ch);
         line_verdict_type v;
         if (func == FUNC_CHAR) begin
            take_byte(ch);
            return;
         end
         if (line_count != '1) line_count++;
         v.number  = line_count;
         v.matched = line_decision();
         verdicts_due.push_back(v);
         clear_line();
      endfunction

      task check_result(input logic [LINE_BITS-1:0] number, input logic matched);
         line_verdict_type v;
         if (verdicts_due.size() == 0) begin
            report($sformatf("result for line %0d with no line closed", number));
            return;
         end
         v = verdicts_due.pop_front();
         lines_closed++;
         if (v.matched) lines_matched++;
         if (number !== v.number)
            report($sformatf("line number %0d, expected %0d", number, v.number));
         if (matched !== v.matched)
            report($sformatf("line %0d match flag %b, expected %b", v.number, matched,
                             v.matched));
      endtask

      task report(input string what);
         fail_count++;
         if (fail_count <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Signals; every input starts at a known value
   // -------------------------------------------------------------------------
   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic                  req_func      = FUNC_CHAR;
   logic [7:0]            req_character = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [LINE_BITS-1:0]  rsp_line_number;
   logic                  rsp_line_matched;
   logic                  psel          = 1'b0;
   logic                  penable       = 1'b0;
   logic                  pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr         = '0;
   logic [CSR_DATA_W-1:0] pwdata        = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   line_verdict_tracker tracker = new();

   bit   tx_gaps_on         = 1'b0;
   bit   rx_stalls_on       = 1'b0;
   bit   hold_off_request   = 1'b0;
   int   items_sent         = 0;
   int   settings_written   = 0;
   int   input_stall_cycles = 0;
   int   cycle_count        = 0;
   logic [7:0] line_text [$];

   anchored_line_substring_matcher_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_character    (req_character),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_number  (rsp_line_number),
      .rsp_line_matched (rsp_line_matched),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // -------------------------------------------------------------------------
   // Result side: random stalls, plus one long hold-off on request. The hold
   // is counted here so the sender keeps offering items meanwhile.
   // -------------------------------------------------------------------------
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RX_HOLD_CYCLES - 1) @(posedge clock);
         end else if (rx_stalls_on && $urandom_range(99) < 6) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: values read here are the ones present just before the edge.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (rsp_valid && rsp_ready) tracker.check_result(rsp_line_number, rsp_line_matched);
         if (req_valid && !req_ready) input_stall_cycles++;
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles without finishing.", CYCLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // Offer one item and hold it until taken. Valid stays high on return, so
   // back-to-back items never drop it.
   task automatic send_item(input logic func, input logic [7:0] ch);
      if (tx_gaps_on && $urandom_range(99) < 3) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_character <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_input(func, ch);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(FUNC_CHAR, s[i]);
   endtask

   // The character of an end-of-line item is ignored; randomise it anyway.
   task automatic send_line();
      foreach (line_text[i]) send_item(FUNC_CHAR, line_text[i]);
      send_item(FUNC_EOL, 8'($urandom_range(255)));
   endtask

   // Drop valid, wait for every pending result, then let trailing bytes clear
   // the pipeline before the register port is touched.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup and access cycles for the write, then the same for a read-back.
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      tracker.write_reg(idx, value);
      settings_written++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== tracker.reg_value(idx))
         tracker.report($sformatf("%s reads %h, expected %h", idx.name(), prdata,
                                  tracker.reg_value(idx)));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] lo, input logic [CSR_DATA_W-1:0] hi,
                            input logic [LEN_BITS-1:0] len, input logic [2:0] mode);
      csr_write(REG_PATTERN_LOW, lo);
      csr_write(REG_PATTERN_HIGH, hi);
      csr_write(REG_PATTERN_LEN, CSR_DATA_W'(len));
      csr_write(REG_MATCH_MODE, CSR_DATA_W'(mode));
   endtask

   // Mostly pattern bytes and a small alphabet so that hits are common; the
   // rest is noise over the full byte range.
   function automatic logic [7:0] filler_byte(input int len);
      int pick;
      pick = $urandom_range(9);
      if (len > 0 && pick < 6) return tracker.pattern_byte($urandom_range(len - 1));
      if (pick < 8) return 8'(8'h61 + $urandom_range(2));
      return 8'($urandom_range(255));
   endfunction

   // Build a line, usually with a copy of the pattern at the start, at index
   // one, at the end, one before the end or anywhere; break the copy at times.
   task automatic build_line(input int max_bytes);
      int len;
      int count;
      int at;
      int tail;
      int j;
      len   = tracker.used_length();
      count = $urandom_range(max_bytes);
      line_text.delete();
      repeat (count) line_text.push_back(filler_byte(len));
      if (len > 0 && $urandom_range(9) < 7) begin
         tail = 0;
         case ($urandom_range(4))
            0: at = 0;
            1: at = 1;
            2: at = count - len;
            3: begin
               at   = count - len - 1;
               tail = 1;
            end
            default: at = $urandom_range(count);
         endcase
         if (at < 0) at = 0;
         while (line_text.size() < at + len + tail) line_text.push_back(filler_byte(len));
         for (j = 0; j < len; j++) line_text[at + j] = tracker.pattern_byte(j);
         if ($urandom_range(4) == 0) begin
            j            = at + $urandom_range(len - 1);
            line_text[j] = line_text[j] ^ 8'h01;
         end
      end
   endtask

   task automatic random_config();
      logic [CSR_DATA_W-1:0] lo;
      logic [CSR_DATA_W-1:0] hi;
      logic [LEN_BITS-1:0]   len;
      int                    i;
      case ($urandom_range(3))
         0: begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
         end
         1: begin
            lo = '1;
            hi = ($urandom_range(1) == 0) ? '1 : '0;
         end
         2: begin
            lo = '0;
            hi = '0;
         end
         default: begin
            for (i = 0; i < 8; i++) begin
               lo[8*i +: 8] = 8'(8'h61 + $urandom_range(2));
               hi[8*i +: 8] = 8'(8'h61 + $urandom_range(2));
            end
         end
      endcase
      case ($urandom_range(5))
         0:       len = '0;
         1:       len = LEN_BITS'(PAT_BYTES);
         2:       len = LEN_BITS'($urandom_range(PAT_BYTES + 1, 31));
         default: len = LEN_BITS'($urandom_range(1, 6));
      endcase
      configure(lo, hi, len, 3'($urandom_range(7)));
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int  start;
      bit  pressure_done;
      pressure_done = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with idling on both sides.
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;

      // Reset settings: empty pattern, contains mode, so even an empty line hits.
      send_item(FUNC_EOL, 8'hFF);
      settle();

      // Empty pattern in exact mode: only an empty line matches.
      csr_write(REG_MATCH_MODE, CSR_DATA_W'(MODE_EXACT));
      send_item(FUNC_EOL, 8'h00);
      send_item(FUNC_CHAR, 8'h00);
      send_item(FUNC_EOL, 8'h5A);
      settle();

      // Empty pattern at index one needs a line of at least one byte.
      csr_write(REG_MATCH_MODE, CSR_DATA_W'(MODE_AT_ONE));
      send_item(FUNC_CHAR, 8'hFF);
      send_item(FUNC_EOL, 8'h00);
      settle();

      // Unused mode never matches.
      csr_write(REG_MATCH_MODE, CSR_DATA_W'(MODE_UNUSED));
      send_item(FUNC_EOL, 8'h00);
      settle();

      // The second occurrence of "aa" in "aaa" starts at index one.
      configure(64'h6161, '0, 5'd2, MODE_AT_ONE);
      send_text("aaa");
      send_item(FUNC_EOL, 8'h00);
      settle();

      // Occurrence ending one byte before the line end.
      csr_write(REG_MATCH_MODE, CSR_DATA_W'(MODE_ENDS_BEFORE));
      send_text("aab");
      send_item(FUNC_EOL, 8'hFF);

      // Change settings in the middle of a line: the hit taken under the old
      // pattern must survive, and an over-long length counts as full depth.
      send_text("aa");
      settle();
      configure('1, '1, 5'd31, MODE_CONTAINS);
      send_item(FUNC_EOL, 8'h00);
      settle();

      // Random phases. Hold idling off for the first stretch, then enable it.
      tx_gaps_on   = 1'b0;
      rx_stalls_on = 1'b0;
      start        = items_sent;
      while (items_sent < start + RANDOM_ITEMS) begin
         if (items_sent >= start + QUIET_ITEMS) begin
            tx_gaps_on   = 1'b1;
            rx_stalls_on = 1'b1;
         end
         random_config();
         if (!pressure_done && items_sent >= start + PRESSURE_AFTER) begin
            // Short lines against a stopped receiver fill the block up.
            pressure_done    = 1'b1;
            hold_off_request = 1'b1;
            repeat (12) begin
               build_line(4);
               send_line();
            end
         end else begin
            repeat ($urandom_range(3, 8)) begin
               build_line(($urandom_range(9) == 0) ? 40 : 16);
               send_line();
            end
            // Leave a line open now and then so the next settings land mid-line.
            if ($urandom_range(2) == 0) begin
               build_line(6);
               foreach (line_text[i]) send_item(FUNC_CHAR, line_text[i]);
            end
         end
         settle();
      end

      // Close any open line, then drain.
      send_item(FUNC_EOL, 8'h00);
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items and %0d lines (%0d matching) across %0d register writes,",
               items_sent, tracker.lines_closed, tracker.lines_matched, settings_written);
      $display("with %0d cycles of input held back while results were not taken.",
               input_stall_cycles);
      if (tracker.fail_count == 0 && tracker.verdicts_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
